### sv/serial_position_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef SERIAL_POSITION_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_POSITION_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SPFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spfr check failed");
// Next-cycle implication, checked out of reset.
`define SPFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spfr check failed");
`else
`define SPFR_ASSERT_IMPL(label, ante, cons)
`define SPFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/spfr_pkg.sv
// Types and frame constants for the serial position frame receiver.
package spfr_pkg;

  localparam int unsigned PAYLOAD_BYTES = 24;
  localparam int unsigned CSUM_BYTES    = 2;

  localparam logic [7:0] HDR_FIRST  = 8'hFC;
  localparam logic [7:0] HDR_SECOND = 8'hFB;
  localparam logic [7:0] FRAME_LEN  = 8'h18;
  localparam logic [7:0] FTR_FIRST  = 8'hFD;
  localparam logic [7:0] FTR_SECOND = 8'hFE;
  localparam logic [7:0] DEVICE_ID_RST = 8'h01;

  localparam logic [4:0] PAYLOAD_LAST = 5'(PAYLOAD_BYTES - 1);
  localparam logic [4:0] CSUM_LAST    = 5'(CSUM_BYTES - 1);

  // Parser phase, one-hot
  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_HDR2    = 8'b0000_0010,
    PH_ID      = 8'b0000_0100,
    PH_LEN     = 8'b0000_1000,
    PH_PAYLOAD = 8'b0001_0000,
    PH_CSUM    = 8'b0010_0000,
    PH_FTR1    = 8'b0100_0000,
    PH_FTR2    = 8'b1000_0000
  } phase_t;

  // Six little-endian payload words of one frame
  typedef struct packed {
    logic [31:0] yaw;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] omega;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
  } frame_words_t;

  // Parser status toward the top level
  typedef struct packed {
    logic emit;     // accepted byte completes a good frame
    logic at_ftr2;  // next byte may complete a frame
  } parse_stat_t;

endpackage

### sv/serial_position_frame_receiver.sv
// Top level of the serial position frame receiver.
//
// Input channel: one serial byte per transfer on in_rx_byte (in_valid/in_ready).
// Output channel: one decoded frame per transfer, six 32-bit float bit patterns
// (out_valid/out_ready), words taken little-endian from the 24 payload bytes.
// cfg_wr_en/cfg_wr_data set the expected device ID byte (reset value 0x01);
// write it only while no frame is in flight.
// Throughput: one byte per cycle unless in_ready is low (see Stall). The parser
// phase, counter and payload shift line update in the cycle a byte is taken.
// Latency: the frame appears on out_valid the cycle after its closing 0xFE
// byte is taken, from the result register.
// Stall: a waiting result does not block input; only the byte that can close
// a frame (second footer position) is held off while the result register is
// still full and out_ready is low.
// Reset (rst_n, synchronous): parser to idle, result register empty, device
// ID back to 0x01. The payload store has no reset; it is fully rewritten by
// every frame before it is read.
module serial_position_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_yaw_bits,
  output logic [31:0] out_pos_x_bits,
  output logic [31:0] out_pos_y_bits,
  output logic [31:0] out_omega_bits,
  output logic [31:0] out_vel_x_bits,
  output logic [31:0] out_vel_y_bits,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import spfr_pkg::*;

  logic [7:0]   device_id_r, device_id_nxt;
  logic         in_fire;
  parse_stat_t  stat;
  frame_words_t words;
  frame_words_t words_q;

  // Device ID register
  assign device_id_nxt = cfg_wr_en ? cfg_wr_data : device_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= DEVICE_ID_RST;
    end else begin
      device_id_r <= device_id_nxt;
    end
  end

  // Hold off only a byte that could load a full result register
  assign in_ready = !out_valid || out_ready || !stat.at_ftr2;
  assign in_fire  = in_valid && in_ready;

  spfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_rx_byte),
    .device_id (device_id_r),
    .stat      (stat),
    .words     (words)
  );

  spfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stat.emit),
    .words     (words),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .words_q   (words_q)
  );

  assign out_yaw_bits   = words_q.yaw;
  assign out_pos_x_bits = words_q.pos_x;
  assign out_pos_y_bits = words_q.pos_y;
  assign out_omega_bits = words_q.omega;
  assign out_vel_x_bits = words_q.vel_x;
  assign out_vel_y_bits = words_q.vel_y;

  `include "serial_position_frame_receiver_assert.svh"

  `SPFR_ASSERT_IMPL(a_no_overwrite, stat.emit, !out_valid || out_ready)
  `SPFR_ASSERT_NEXT(a_emit_shows, stat.emit, out_valid)

endmodule

### sv/spfr_parser.sv
// Frame parser: phase tracking, byte counter and payload shift store.
module spfr_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            device_id,
  output spfr_pkg::parse_stat_t stat,
  output spfr_pkg::frame_words_t words
);
  import spfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  count_r, count_nxt;
  logic        shift_en;
  logic        emit;
  logic [PAYLOAD_BYTES-1:0][7:0] store_r;

  // Next phase and counter for the accepted byte
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    shift_en  = 1'b0;
    emit      = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (rx_byte == HDR_FIRST) phase_nxt = PH_HDR2;
        end
        PH_HDR2: begin
          phase_nxt = (rx_byte == HDR_SECOND) ? PH_ID : PH_IDLE;
        end
        PH_ID: begin
          phase_nxt = (rx_byte == device_id) ? PH_LEN : PH_IDLE;
        end
        PH_LEN: begin
          if (rx_byte == FRAME_LEN) begin
            phase_nxt = PH_PAYLOAD;
            count_nxt = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_PAYLOAD: begin
          shift_en = 1'b1;
          if (count_r == PAYLOAD_LAST) begin
            phase_nxt = PH_CSUM;
            count_nxt = '0;
          end else begin
            count_nxt = count_r + 5'd1;
          end
        end
        PH_CSUM: begin
          // checksum bytes are skipped unchecked
          if (count_r == CSUM_LAST) begin
            phase_nxt = PH_FTR1;
            count_nxt = '0;
          end else begin
            count_nxt = count_r + 5'd1;
          end
        end
        PH_FTR1: begin
          phase_nxt = (rx_byte == FTR_FIRST) ? PH_FTR2 : PH_IDLE;
        end
        PH_FTR2: begin
          emit      = (rx_byte == FTR_SECOND);
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload shift line: first payload byte ends up in entry 0
  always_ff @(posedge clk) begin
    if (shift_en) begin
      store_r <= {rx_byte, store_r[PAYLOAD_BYTES-1:1]};
    end
  end

  // Little-endian word assembly
  assign words.yaw   = {store_r[3],  store_r[2],  store_r[1],  store_r[0]};
  assign words.pos_x = {store_r[7],  store_r[6],  store_r[5],  store_r[4]};
  assign words.pos_y = {store_r[11], store_r[10], store_r[9],  store_r[8]};
  assign words.omega = {store_r[15], store_r[14], store_r[13], store_r[12]};
  assign words.vel_x = {store_r[19], store_r[18], store_r[17], store_r[16]};
  assign words.vel_y = {store_r[23], store_r[22], store_r[21], store_r[20]};

  assign stat.emit    = emit;
  assign stat.at_ftr2 = (phase_r == PH_FTR2);

  `include "serial_position_frame_receiver_assert.svh"

  `SPFR_ASSERT_IMPL(a_count_range, 1'b1, count_r <= PAYLOAD_LAST)
  `SPFR_ASSERT_NEXT(a_payload_done, in_fire && phase_r == PH_PAYLOAD && count_r == PAYLOAD_LAST, phase_r == PH_CSUM)
  `SPFR_ASSERT_NEXT(a_emit_to_idle, emit, phase_r == PH_IDLE)

endmodule

### sv/spfr_out_reg.sv
// Result register holding one decoded frame until the consumer takes it.
module spfr_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  spfr_pkg::frame_words_t words,
  input  logic                   out_ready,
  output logic                   out_valid,
  output spfr_pkg::frame_words_t words_q
);
  import spfr_pkg::*;

  logic         valid_r, valid_nxt;
  frame_words_t words_r;

  // Valid: set on load, cleared on transfer
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      words_r <= words;
    end
  end

  assign out_valid = valid_r;
  assign words_q   = words_r;

endmodule
